// ----- hdl/cbg_pkg.sv -----
// ----------------------------------------------------------------------------
// cbg_pkg: shared types and constants for the cholesky gradient block
// beat layouts, divider handshake structs and reset values
// ----------------------------------------------------------------------------
package cbg_pkg;

  localparam int MAX_ORDER_DEF  = 8;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS      = 16;
  localparam int QUOT_BITS      = 48;

  localparam logic [3:0] SIZE_RESET      = 4'd8;
  // register index carried on paddr[2]
  localparam logic       REG_MATRIX_SIZE = 1'b0;

  typedef struct packed {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] grad_in;
    logic signed [31:0] factor_in;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] grad_out;
    logic               error_flag;
    logic               last_out;
  } out_item_t;

  typedef struct packed {
    logic               go;
    logic signed [31:0] num;
    logic signed [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
    logic               err;
  } div_res_t;

endpackage

// ----- hdl/cbg_div.sv -----
// ----------------------------------------------------------------------------
// cbg_div: iterative signed fixed-point divider
// computes sat((num * 2^16) / den) one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module cbg_div #(
  parameter int SAT_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cbg_pkg::div_req_t req,
  output cbg_pkg::div_res_t res
);
  import cbg_pkg::*;

  localparam logic signed [63:0] SMAX = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t              st_r, st_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic [QUOT_BITS-1:0] num_r, num_nxt;
  logic [32:0]          den_r, den_nxt;
  logic [32:0]          rem_r, rem_nxt;
  logic                 neg_r, neg_nxt;
  logic                 zero_r, zero_nxt;

  logic [31:0]          amag;
  logic [33:0]          dabs;
  logic [33:0]          remsh;
  logic signed [63:0]   qs;

  // magnitudes of the operands
  assign amag  = req.num[31] ? (~req.num + 32'd1) : req.num;
  assign dabs  = req.den[33] ? (~req.den + 34'd1) : req.den;
  assign remsh = {rem_r, num_r[QUOT_BITS-1]};
  assign qs    = neg_r ? -64'({1'b0, num_r}) : 64'({1'b0, num_r});

  // sequencer for the restoring steps
  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    case (st_r)
      D_IDLE: begin
        if (req.go) begin
          zero_nxt = (req.den == 34'sd0);
          num_nxt  = {amag, 16'd0};
          den_nxt  = dabs[32:0];
          rem_nxt  = '0;
          neg_nxt  = req.num[31] ^ req.den[33];
          cnt_nxt  = 6'(QUOT_BITS);
          st_nxt   = (req.den == 34'sd0) ? D_FIN : D_RUN;
        end
      end
      D_RUN: begin
        if (remsh >= {1'b0, den_r}) begin
          rem_nxt = 33'(remsh - {1'b0, den_r});
          num_nxt = {num_r[QUOT_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = remsh[32:0];
          num_nxt = {num_r[QUOT_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) st_nxt = D_FIN;
      end
      D_FIN: begin
        st_nxt = D_IDLE;
      end
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  // result with saturation, zero pivot gives zero
  always_comb begin
    res.done = (st_r == D_FIN);
    res.err  = 1'b0;
    res.quot = qs[31:0];
    if (zero_r) begin
      res.err  = 1'b1;
      res.quot = '0;
    end else if (qs > SMAX) begin
      res.err  = 1'b1;
      res.quot = SMAX[31:0];
    end else if (qs < SMIN) begin
      res.err  = 1'b1;
      res.quot = SMIN[31:0];
    end
  end

endmodule

// ----- hdl/cholesky_backprop_gradient.sv -----
// ----------------------------------------------------------------------------
// cholesky_backprop_gradient: reverse-mode gradient of a cholesky factor
// loads dL and the factor, runs the backward sweep, streams out dA
// ----------------------------------------------------------------------------
// usage
//   input beats: start with in_data while busy is low; each beat stores one
//   lower-triangle entry of dL and the factor. a beat with last_in set is
//   stored and then starts the sweep; busy stays high until the final
//   result has been issued.
//   results: one beat per lower-triangle entry, row-major, shown for one
//   cycle with out_strobe; the receiver cannot stall, so nothing is held.
//   config: matrix_size at byte address 0 over the apb port; the user must
//   write it only while idle (not enforced by the block). pready is tied high.
// sweep
//   a sweep is set by the one shared multiply/subtract unit (n-k terms per
//   entry of column k) and the bit-serial divider (n(n+1)/2 divisions),
//   then the results are streamed out.
// reset
//   matrix_size returns to 8, the error flag clears; the stores are not
//   cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module cholesky_backprop_gradient #(
  parameter int MAX_ORDER  = cbg_pkg::MAX_ORDER_DEF,
  parameter int DATA_WIDTH = cbg_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  cbg_pkg::in_item_t   in_data,
  output logic                out_strobe,
  output cbg_pkg::out_item_t  out_data
);
  import cbg_pkg::*;

  localparam int SAT_W  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ORD_W  = $clog2(MAX_ORDER + 1);
  localparam logic signed [63:0] SMAX = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

  typedef enum logic [4:0] {
    S_IDLE, S_K_RD, S_K_LD, S_A_RD, S_A_LD, S_T_RD, S_T_MUL, S_T_SUB,
    S_A_WR, S_B_RD, S_B_DIV, S_B_WAIT, S_B_MUL, S_B_SUB, S_C_DIV,
    S_C_WAIT, S_EMIT
  } state_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [3:0] r,
                                                input logic [3:0] c);
    logic [15:0] t;
    t = 16'(r) * 16'(MAX_ORDER) + 16'(c);
    return t[ADDR_W-1:0];
  endfunction

  // saturate to the data range, top bit flags a clip
  function automatic logic [32:0] sat64(input logic signed [63:0] v);
    if (v > SMAX) return {1'b1, SMAX[31:0]};
    if (v < SMIN) return {1'b1, SMIN[31:0]};
    return {1'b0, v[31:0]};
  endfunction

  state_t             state_r, state_nxt;
  logic [ORD_W-1:0]   k_r, k_nxt, i_r, i_nxt, j_r, j_nxt, n_r, n_nxt;
  logic               pass_r, pass_nxt;
  logic [3:0]         size_r, size_nxt;
  logic signed [31:0] acc_r, acc_nxt, dkk_r, dkk_nxt, ukk_r, ukk_nxt;
  logic signed [31:0] uki_r, uki_nxt, q_r, q_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic               err_r, err_nxt;
  logic               ov_r, ov_nxt, olast_r, olast_nxt;
  logic [2:0]         orow_r, orow_nxt, ocol_r, ocol_nxt;

  logic signed [31:0] g_mem [DEPTH];
  logic signed [31:0] f_mem [DEPTH];
  logic signed [31:0] g_q_r, f_q_r;
  logic [ADDR_W-1:0]  g_raddr, f_raddr, g_waddr;
  logic               g_we, f_we;
  logic signed [31:0] g_wdata;

  div_req_t           dreq;
  div_res_t           dres;

  logic [ORD_W-1:0]   nm1;
  logic               accept, cfg_wr, in_range;
  logic [3:0]         n_clamp;
  logic signed [31:0] mul_a, mul_b, sub_a, mval;
  logic signed [63:0] rnd;
  logic [32:0]        mres, sres;

  assign nm1      = n_r - ORD_W'(1);
  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);
  assign in_range = (int'(in_data.row) < MAX_ORDER) && (int'(in_data.col) < MAX_ORDER);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_MATRIX_SIZE) ? {28'd0, size_r} : 32'd0;

  // effective order, clamped to one .. MAX_ORDER
  always_comb begin
    n_clamp = size_r;
    if (size_r == 4'd0) n_clamp = 4'd1;
    else if (int'(size_r) > MAX_ORDER) n_clamp = 4'(MAX_ORDER);
  end

  // shared multiply, round and subtract unit
  assign mul_a    = (state_r == S_T_MUL) ? g_q_r : uki_r;
  assign mul_b    = (state_r == S_T_MUL) ? f_q_r : q_r;
  assign rnd      = (prod_r + 64'sd32768) >>> FRAC_BITS;
  assign mres     = sat64(rnd);
  assign mval     = signed'(mres[31:0]);
  assign sub_a    = (state_r == S_B_SUB) ? dkk_r : acc_r;
  assign sres     = sat64(64'(sub_a) - 64'(mval));

  // store addressing
  always_comb begin
    g_raddr = addr_of(4'(i_r), 4'(j_r));
    f_raddr = addr_of(4'(j_r), 4'(k_r));
    case (state_r)
      S_K_RD: begin
        g_raddr = addr_of(4'(k_r), 4'(k_r));
        f_raddr = addr_of(4'(k_r), 4'(k_r));
      end
      S_A_RD:  g_raddr = addr_of(4'(i_r), 4'(k_r));
      S_T_RD:  g_raddr = pass_r ? addr_of(4'(j_r), 4'(i_r)) : addr_of(4'(i_r), 4'(j_r));
      S_B_RD: begin
        g_raddr = addr_of(4'(i_r), 4'(k_r));
        f_raddr = addr_of(4'(i_r), 4'(k_r));
      end
      default: ;
    endcase
  end

  always_comb begin
    g_we    = 1'b0;
    f_we    = 1'b0;
    g_waddr = addr_of(4'(i_r), 4'(k_r));
    g_wdata = acc_r;
    case (state_r)
      S_IDLE: begin
        g_we    = accept && in_range;
        f_we    = accept && in_range;
        g_waddr = addr_of(4'(in_data.row), 4'(in_data.col));
        g_wdata = in_data.grad_in;
      end
      S_A_WR:   g_we = 1'b1;
      S_B_WAIT: begin
        g_we    = dres.done;
        g_wdata = dres.quot;
      end
      S_C_WAIT: begin
        g_we    = dres.done;
        g_waddr = addr_of(4'(k_r), 4'(k_r));
        g_wdata = dres.quot;
      end
      default: ;
    endcase
  end

  // divider requests
  always_comb begin
    dreq.go  = (state_r == S_B_DIV) || (state_r == S_C_DIV);
    dreq.num = (state_r == S_C_DIV) ? dkk_r : g_q_r;
    dreq.den = (state_r == S_C_DIV) ? (34'(ukk_r) <<< 1) : 34'(ukk_r);
  end

  // sweep sequencer
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    pass_nxt  = pass_r;
    size_nxt  = cfg_wr ? pwdata[3:0] : size_r;
    acc_nxt   = acc_r;
    dkk_nxt   = dkk_r;
    ukk_nxt   = ukk_r;
    uki_nxt   = uki_r;
    q_nxt     = q_r;
    prod_nxt  = prod_r;
    err_nxt   = err_r;
    ov_nxt    = 1'b0;
    olast_nxt = 1'b0;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_data.last_in) begin
          n_nxt     = ORD_W'(n_clamp);
          k_nxt     = ORD_W'(n_clamp - 4'd1);
          err_nxt   = 1'b0;
          state_nxt = S_K_RD;
        end
      end
      S_K_RD: state_nxt = S_K_LD;
      S_K_LD: begin
        dkk_nxt = g_q_r;
        ukk_nxt = f_q_r;
        i_nxt   = k_r + ORD_W'(1);
        state_nxt = (k_r == nm1) ? S_C_DIV : S_A_RD;
      end
      S_A_RD: state_nxt = S_A_LD;
      S_A_LD: begin
        acc_nxt   = g_q_r;
        j_nxt     = k_r + ORD_W'(1);
        pass_nxt  = 1'b0;
        state_nxt = S_T_RD;
      end
      S_T_RD: state_nxt = S_T_MUL;
      S_T_MUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_T_SUB;
      end
      S_T_SUB: begin
        acc_nxt   = signed'(sres[31:0]);
        err_nxt   = err_r | mres[32] | sres[32];
        state_nxt = S_T_RD;
        if (!pass_r) begin
          if (j_r == i_r) pass_nxt = 1'b1;
          else j_nxt = j_r + ORD_W'(1);
        end else if (j_r == nm1) begin
          state_nxt = S_A_WR;
        end else begin
          j_nxt = j_r + ORD_W'(1);
        end
      end
      S_A_WR: begin
        if (i_r == nm1) begin
          i_nxt     = k_r + ORD_W'(1);
          state_nxt = S_B_RD;
        end else begin
          i_nxt     = i_r + ORD_W'(1);
          state_nxt = S_A_RD;
        end
      end
      S_B_RD: state_nxt = S_B_DIV;
      S_B_DIV: begin
        uki_nxt   = f_q_r;
        state_nxt = S_B_WAIT;
      end
      S_B_WAIT: begin
        if (dres.done) begin
          q_nxt     = dres.quot;
          err_nxt   = err_r | dres.err;
          state_nxt = S_B_MUL;
        end
      end
      S_B_MUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_B_SUB;
      end
      S_B_SUB: begin
        dkk_nxt = signed'(sres[31:0]);
        err_nxt = err_r | mres[32] | sres[32];
        if (i_r == nm1) begin
          state_nxt = S_C_DIV;
        end else begin
          i_nxt     = i_r + ORD_W'(1);
          state_nxt = S_B_RD;
        end
      end
      S_C_DIV: state_nxt = S_C_WAIT;
      S_C_WAIT: begin
        if (dres.done) begin
          err_nxt = err_r | dres.err;
          if (k_r == '0) begin
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = S_EMIT;
          end else begin
            k_nxt     = k_r - ORD_W'(1);
            state_nxt = S_K_RD;
          end
        end
      end
      S_EMIT: begin
        ov_nxt    = 1'b1;
        orow_nxt  = 3'(i_r);
        ocol_nxt  = 3'(j_r);
        olast_nxt = (i_r == nm1) && (j_r == i_r);
        if (j_r == i_r) begin
          j_nxt = '0;
          if (i_r == nm1) state_nxt = S_IDLE;
          else i_nxt = i_r + ORD_W'(1);
        end else begin
          j_nxt = j_r + ORD_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_r  <= SIZE_RESET;
      err_r   <= 1'b0;
      ov_r    <= 1'b0;
      olast_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
      olast_r <= olast_nxt;
    end
    k_r    <= k_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    n_r    <= n_nxt;
    pass_r <= pass_nxt;
    acc_r  <= acc_nxt;
    dkk_r  <= dkk_nxt;
    ukk_r  <= ukk_nxt;
    uki_r  <= uki_nxt;
    q_r    <= q_nxt;
    prod_r <= prod_nxt;
    orow_r <= orow_nxt;
    ocol_r <= ocol_nxt;
  end

  // gradient and factor stores
  always_ff @(posedge clk) begin
    if (g_we) g_mem[g_waddr] <= g_wdata;
    g_q_r <= g_mem[g_raddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) f_mem[g_waddr] <= in_data.factor_in;
    f_q_r <= f_mem[f_raddr];
  end

  cbg_div #(
    .SAT_W (SAT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .res   (dres)
  );

  // result beat
  assign out_strobe          = ov_r;
  assign out_data.out_row    = orow_r;
  assign out_data.out_col    = ocol_r;
  assign out_data.grad_out   = g_q_r;
  assign out_data.error_flag = err_r;
  assign out_data.last_out   = olast_r && ov_r;

  a_strobe_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without a running sweep");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last_out) |-> !busy)
    else $error("still busy after the final result");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.last_in) |=> busy)
    else $error("sweep not started on last beat");

  a_div_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    dres.done |-> (state_r == S_B_WAIT || state_r == S_C_WAIT))
    else $error("divider finished while not awaited");

endmodule
